// ----- hdl/clws_pkg.sv -----
// Shared types, constants and the microprogram for the character-LCD write sequencer.
// Depends on nothing; the digit unit, sequencer, top level and testbench import it.
package clws_pkg;

  localparam int UPC_W = 4;
  localparam int NUM_DIGITS = 10;
  localparam int DIG_CNT_W = 4;
  localparam int CONV_CNT_W = 5;
  localparam int NUMBER_W = 32;
  localparam int BCD_W = 4 * NUM_DIGITS;

  localparam logic [7:0] LCD_FUNC_SET = 8'h38;
  localparam logic [7:0] LCD_DISP_ON = 8'h0C;
  localparam logic [7:0] LCD_CLEAR = 8'h01;
  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_COMMAND = 3'd1,
    OP_CHAR    = 3'd2,
    OP_GOTO    = 3'd3,
    OP_NUMBER  = 3'd4,
    OP_GLYPH   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    SRC_CONST,
    SRC_BYTE,
    SRC_GOTO,
    SRC_CGADDR,
    SRC_PAT,
    SRC_SLOT,
    SRC_DIGIT
  } src_t;

  typedef enum logic [2:0] {
    SQ_NEXT,
    SQ_END,
    SQ_PLOOP,
    SQ_WAIT,
    SQ_DLOOP
  } seq_t;

  typedef struct packed {
    logic       emit;
    logic       rs;
    logic       last;
    src_t       src;
    logic [7:0] konst;
    seq_t       seq;
  } uword_t;

  typedef struct packed {
    logic   busy;
    logic   fire;
    logic   last;
    uword_t word;
  } seq_ctl_t;

  typedef struct packed {
    logic can_emit;
    logic dig_ready;
    logic dig_last;
    logic idx_last;
  } seq_stat_t;

  typedef struct packed {
    logic       ready;
    logic       last;
    logic [3:0] digit;
  } dig_stat_t;

  localparam logic [UPC_W-1:0] UA_INIT  = 4'd0;
  localparam logic [UPC_W-1:0] UA_CMD   = 4'd3;
  localparam logic [UPC_W-1:0] UA_CHR   = 4'd4;
  localparam logic [UPC_W-1:0] UA_GOTO  = 4'd5;
  localparam logic [UPC_W-1:0] UA_NUM   = 4'd6;
  localparam logic [UPC_W-1:0] UA_GLYPH = 4'd8;

  function automatic uword_t mk(input logic emit, input logic rs, input logic last,
                                input src_t src, input logic [7:0] konst, input seq_t seq);
    uword_t w;
    w.emit  = emit;
    w.rs    = rs;
    w.last  = last;
    w.src   = src;
    w.konst = konst;
    w.seq   = seq;
    return w;
  endfunction

  // The program: one word per step. Loops hold the step counter until their exit condition.
  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      4'd0:    w = mk(1'b1, 1'b0, 1'b0, SRC_CONST,  LCD_FUNC_SET, SQ_NEXT);
      4'd1:    w = mk(1'b1, 1'b0, 1'b0, SRC_CONST,  LCD_DISP_ON,  SQ_NEXT);
      4'd2:    w = mk(1'b1, 1'b0, 1'b1, SRC_CONST,  LCD_CLEAR,    SQ_END);
      4'd3:    w = mk(1'b1, 1'b0, 1'b1, SRC_BYTE,   8'h00,        SQ_END);
      4'd4:    w = mk(1'b1, 1'b1, 1'b1, SRC_BYTE,   8'h00,        SQ_END);
      4'd5:    w = mk(1'b1, 1'b0, 1'b1, SRC_GOTO,   8'h00,        SQ_END);
      4'd6:    w = mk(1'b0, 1'b0, 1'b0, SRC_CONST,  8'h00,        SQ_WAIT);
      4'd7:    w = mk(1'b1, 1'b1, 1'b0, SRC_DIGIT,  8'h00,        SQ_DLOOP);
      4'd8:    w = mk(1'b1, 1'b0, 1'b0, SRC_CGADDR, 8'h00,        SQ_NEXT);
      4'd9:    w = mk(1'b1, 1'b1, 1'b0, SRC_PAT,    8'h00,        SQ_PLOOP);
      4'd10:   w = mk(1'b1, 1'b0, 1'b0, SRC_GOTO,   8'h00,        SQ_NEXT);
      4'd11:   w = mk(1'b1, 1'b1, 1'b1, SRC_SLOT,   8'h00,        SQ_END);
      default: w = mk(1'b0, 1'b0, 1'b0, SRC_CONST,  8'h00,        SQ_END);
    endcase
    return w;
  endfunction

  function automatic logic [UPC_W-1:0] entry_of(input op_t op);
    logic [UPC_W-1:0] a;
    unique case (op)
      OP_INIT:    a = UA_INIT;
      OP_COMMAND: a = UA_CMD;
      OP_CHAR:    a = UA_CHR;
      OP_GOTO:    a = UA_GOTO;
      OP_NUMBER:  a = UA_NUM;
      OP_GLYPH:   a = UA_GLYPH;
      default:    a = UA_INIT;
    endcase
    return a;
  endfunction

  function automatic logic op_known(input logic [2:0] op);
    return op <= OP_GLYPH;
  endfunction

endpackage

// ----- hdl/clws_channels.sv -----
// Request and bus-write channel interfaces of the character-LCD write sequencer.
// Depends on nothing but the field widths, which are fixed.
interface clws_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  byte_value;
  logic        row;
  logic [5:0]  column;
  logic [31:0] number;
  logic [63:0] pattern;
  logic [2:0]  pattern_slot;

  modport source (output valid, op, byte_value, row, column, number, pattern, pattern_slot,
                  input ready);
  modport sink (input valid, op, byte_value, row, column, number, pattern, pattern_slot,
                output ready);
endinterface

interface clws_out_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [7:0] bus_byte;
  logic       last;

  modport source (output valid, register_select, bus_byte, last, input ready);
  modport sink (input valid, register_select, bus_byte, last, output ready);
endinterface

// ----- hdl/clws_digits.sv -----
// Binary to decimal unit: shift-and-add-3 conversion, one bit per cycle, then leading-zero
// removal and digit delivery most significant first. Depends on clws_pkg.
module clws_digits (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [clws_pkg::NUMBER_W-1:0] value,
  input  logic                          pop,
  output clws_pkg::dig_stat_t           stat
);
  import clws_pkg::*;

  typedef enum logic [1:0] {D_IDLE, D_CONV, D_NORM, D_READY} dstate_t;

  dstate_t               state_r;
  logic [NUMBER_W-1:0]   bin_r;
  logic [BCD_W-1:0]      bcd_r;
  logic [BCD_W-1:0]      adj;
  logic [CONV_CNT_W-1:0] cnt_r;
  logic [DIG_CNT_W-1:0]  ndig_r;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            bin_r   <= value;
            bcd_r   <= '0;
            cnt_r   <= '0;
            state_r <= D_CONV;
          end
        end
        D_CONV: begin
          bcd_r <= {adj[BCD_W-2:0], bin_r[NUMBER_W-1]};
          bin_r <= {bin_r[NUMBER_W-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CONV_CNT_W'(NUMBER_W - 1)) begin
            ndig_r  <= DIG_CNT_W'(NUM_DIGITS);
            state_r <= D_NORM;
          end
        end
        D_NORM: begin
          // Strip leading zeros, but always keep one digit so zero prints as '0'.
          if (bcd_r[BCD_W-1 -: 4] == 4'd0 && ndig_r != DIG_CNT_W'(1)) begin
            bcd_r  <= {bcd_r[BCD_W-5:0], 4'd0};
            ndig_r <= ndig_r - 1'b1;
          end else begin
            state_r <= D_READY;
          end
        end
        D_READY: begin
          if (pop) begin
            bcd_r  <= {bcd_r[BCD_W-5:0], 4'd0};
            ndig_r <= ndig_r - 1'b1;
            if (ndig_r == DIG_CNT_W'(1)) begin
              state_r <= D_IDLE;
            end
          end
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign stat.ready = (state_r == D_READY);
  assign stat.last  = (ndig_r == DIG_CNT_W'(1));
  assign stat.digit = bcd_r[BCD_W-1 -: 4];

endmodule

// ----- hdl/clws_sequencer.sv -----
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
// Depends on clws_pkg for the control word layout and the program.
module clws_sequencer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  clws_pkg::op_t             op,
  input  clws_pkg::seq_stat_t       stat,
  output clws_pkg::seq_ctl_t        ctl
);
  import clws_pkg::*;

  logic             busy_r;
  logic             busy_nxt;
  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  uword_t           word;
  logic             fire;

  assign word = ucode_rom(upc_r);

  always_comb begin
    if (word.emit) begin
      fire = busy_r && stat.can_emit;
    end else if (word.seq == SQ_WAIT) begin
      fire = busy_r && stat.dig_ready;
    end else begin
      fire = busy_r;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    if (start) begin
      busy_nxt = 1'b1;
      upc_nxt  = entry_of(op);
    end else if (fire) begin
      unique case (word.seq) inside
        SQ_NEXT, SQ_WAIT: upc_nxt = upc_r + 1'b1;
        SQ_END:           busy_nxt = 1'b0;
        SQ_PLOOP: begin
          if (stat.idx_last) begin
            upc_nxt = upc_r + 1'b1;
          end
        end
        SQ_DLOOP: begin
          if (stat.dig_last) begin
            busy_nxt = 1'b0;
          end
        end
        default: busy_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    upc_r <= upc_nxt;
  end

  assign ctl.busy = busy_r;
  assign ctl.fire = fire;
  assign ctl.word = word;
  assign ctl.last = word.last || (word.seq == SQ_DLOOP && stat.dig_last);

endmodule

// ----- hdl/char_lcd_write_sequencer.sv -----
// Character-LCD write sequencer top level: request capture, byte datapath, output register.
// Depends on clws_pkg, clws_channels, clws_digits and clws_sequencer.
//
// Usage: a request on in_ch selects one of six operations (init, raw command, character,
// goto, number, custom glyph). It becomes a run of bus writes on out_ch, each tagged as
// command (register_select 0) or data (register_select 1), with last set on the final one.
// Unknown op codes are taken and produce no writes.
// in_ch.ready is high while no run is in progress; one request is worked on at a time.
// A write is registered at its program step and appears on out_ch in the cycle after it;
// further writes follow back to back while out_ch.ready stays high, and the next request
// can be taken in the cycle after the last step.
// Numbers first pass through the decimal unit (bit-serial conversion of all 32 bits, then
// leading-zero stripping) while the program holds on one wait step; then comes one write
// per digit. Stripped zeros and digits always add up to ten.
// A stalled receiver holds the output register; the program simply waits on that step.
// Reset (rst_n low at a clock edge) ends any run and drops a pending write.
module char_lcd_write_sequencer (
  input  logic             clk,
  input  logic             rst_n,
  clws_in_if.sink          in_ch,
  clws_out_if.source       out_ch
);
  import clws_pkg::*;

  seq_ctl_t   ctl;
  seq_stat_t  sstat;
  dig_stat_t  dstat;
  logic       accept;
  logic       start;
  logic       dig_pop;
  logic [7:0] sel_byte;
  logic       emit_now;

  logic [7:0]  byte_r;
  logic        row_r;
  logic [5:0]  col_r;
  logic [63:0] pat_r;
  logic [2:0]  slot_r;
  logic [2:0]  idx_r;

  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_rs_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  assign in_ch.ready = !ctl.busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign start       = accept && op_known(in_ch.op);

  clws_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (op_t'(in_ch.op)),
    .stat  (sstat),
    .ctl   (ctl)
  );

  clws_digits u_digits (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start && in_ch.op == OP_NUMBER),
    .value (in_ch.number),
    .pop   (dig_pop),
    .stat  (dstat)
  );

  assign sstat.can_emit  = !out_valid_r || out_ch.ready;
  assign sstat.dig_ready = dstat.ready;
  assign sstat.dig_last  = dstat.last;
  assign sstat.idx_last  = (idx_r == 3'd7);

  assign emit_now = ctl.fire && ctl.word.emit;
  assign dig_pop  = emit_now && ctl.word.src == SRC_DIGIT;

  always_comb begin
    case (ctl.word.src)
      SRC_CONST:  sel_byte = ctl.word.konst;
      SRC_BYTE:   sel_byte = byte_r;
      SRC_GOTO:   sel_byte = {1'b1, row_r, col_r};
      SRC_CGADDR: sel_byte = {2'b01, slot_r, 3'b000};
      SRC_PAT:    sel_byte = pat_r[7:0];
      SRC_SLOT:   sel_byte = {5'b00000, slot_r};
      SRC_DIGIT:  sel_byte = ASCII_ZERO + {4'b0000, dstat.digit};
      default:    sel_byte = ctl.word.konst;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_ch.byte_value;
      row_r  <= in_ch.row;
      col_r  <= in_ch.column;
      pat_r  <= in_ch.pattern;
      slot_r <= in_ch.pattern_slot;
      idx_r  <= 3'd0;
    end else if (emit_now && ctl.word.src == SRC_PAT) begin
      pat_r <= {8'h00, pat_r[63:8]};
      idx_r <= idx_r + 1'b1;
    end
  end

  always_comb begin
    if (emit_now) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (emit_now) begin
      out_rs_r   <= ctl.word.rs;
      out_byte_r <= sel_byte;
      out_last_r <= ctl.last;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.register_select = out_rs_r;
  assign out_ch.bus_byte        = out_byte_r;
  assign out_ch.last            = out_last_r;

endmodule

// ----- bench/tb_char_lcd_write_sequencer.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the character-LCD write sequencer: drives requests, predicts
// each run of bus writes and checks every write in order. Depends on clws_pkg,
// clws_channels and char_lcd_write_sequencer.
module tb_char_lcd_write_sequencer;
  import clws_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 90;
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  byte_value;
    logic        row;
    logic [5:0]  column;
    logic [31:0] number;
    logic [63:0] pattern;
    logic [2:0]  pattern_slot;
  } lcd_request_t;

  typedef struct packed {
    logic       rs;
    logic [7:0] data;
    logic       last;
  } bus_write_t;

  logic clk;
  logic rst_n;

  clws_in_if  in_ch ();
  clws_out_if out_ch ();

  char_lcd_write_sequencer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lcd_request_t pending_reqs[$];
  bus_write_t   expected_writes[$];
  lcd_request_t cur_req;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           mismatch_count;
  int           cycle_count;
  bit           hold_armed;
  bit           hold_seen;
  int           hold_left;

  // Expected bus writes of one request, appended in the order the block must send them.
  function automatic void predict_bus_writes(input lcd_request_t r);
    bus_write_t  run[$];
    logic [7:0]  digits[$];
    logic [31:0] v;
    case (r.op)
      OP_INIT: begin
        run.push_back('{1'b0, LCD_FUNC_SET, 1'b0});
        run.push_back('{1'b0, LCD_DISP_ON, 1'b0});
        run.push_back('{1'b0, LCD_CLEAR, 1'b0});
      end
      OP_COMMAND: run.push_back('{1'b0, r.byte_value, 1'b0});
      OP_CHAR:    run.push_back('{1'b1, r.byte_value, 1'b0});
      OP_GOTO:    run.push_back('{1'b0, {1'b1, r.row, r.column}, 1'b0});
      OP_NUMBER: begin
        v = r.number;
        if (v == 0) begin
          digits.push_back(ASCII_ZERO);
        end
        while (v != 0) begin
          digits.push_front(ASCII_ZERO + 8'(v % 10));
          v = v / 10;
        end
        foreach (digits[i]) run.push_back('{1'b1, digits[i], 1'b0});
      end
      OP_GLYPH: begin
        run.push_back('{1'b0, {2'b01, r.pattern_slot, 3'b000}, 1'b0});
        for (int i = 0; i < 8; i++) begin
          run.push_back('{1'b1, r.pattern[8*i +: 8], 1'b0});
        end
        run.push_back('{1'b0, {1'b1, r.row, r.column}, 1'b0});
        run.push_back('{1'b1, {5'b0, r.pattern_slot}, 1'b0});
      end
      default: ;
    endcase
    if (run.size() != 0) begin
      run[run.size()-1].last = 1'b1;
    end
    foreach (run[i]) expected_writes.push_back(run[i]);
  endfunction

  task automatic add_req(input logic [2:0] op, input logic [7:0] byte_value, input logic row,
                         input logic [5:0] column, input logic [31:0] number,
                         input logic [63:0] pattern, input logic [2:0] slot);
    lcd_request_t r;
    r.op = op;
    r.byte_value = byte_value;
    r.row = row;
    r.column = column;
    r.number = number;
    r.pattern = pattern;
    r.pattern_slot = slot;
    pending_reqs.push_back(r);
  endtask

  // Queues random requests until n of them use a known op; unknown ops ride along as noise.
  task automatic add_random_reqs(input int n);
    lcd_request_t r;
    int known;
    known = 0;
    while (known < n) begin
      r.op = ($urandom_range(0, 99) < 6) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      r.byte_value = 8'($urandom);
      r.row = 1'($urandom);
      r.column = 6'($urandom);
      case ($urandom_range(0, 3))
        0: r.number = $urandom;
        1: r.number = $urandom_range(0, 9);
        2: r.number = $urandom_range(0, 99999);
        default: r.number = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      endcase
      r.pattern = {$urandom, $urandom};
      r.pattern_slot = 3'($urandom);
      if (r.op <= OP_GLYPH) begin
        known++;
      end
      pending_reqs.push_back(r);
    end
  endtask

  task automatic wait_drained;
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || expected_writes.size() != 0);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Request driver: holds a request until it is taken, then predicts its run.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_bus_writes(cur_req);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.op           <= cur_req.op;
          in_ch.byte_value   <= cur_req.byte_value;
          in_ch.row          <= cur_req.row;
          in_ch.column       <= cur_req.column;
          in_ch.number       <= cur_req.number;
          in_ch.pattern      <= cur_req.pattern;
          in_ch.pattern_slot <= cur_req.pattern_slot;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started by the stimulus and counted down here.
  always @(posedge clk) begin
    if (hold_armed != hold_seen) begin
      hold_seen <= hold_armed;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Bus write checker.
  always @(posedge clk) begin
    bus_write_t got;
    bus_write_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.register_select, out_ch.bus_byte, out_ch.last};
        if (expected_writes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected write: rs=%0b byte=%02h last=%0b", got.rs, got.data, got.last);
          end
        end else begin
          want = expected_writes.pop_front();
          if (got.rs !== want.rs || got.data !== want.data || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $write("write mismatch: expected rs=%0b byte=%02h last=%0b,",
                     want.rs, want.data, want.last);
              $display(" got rs=%0b byte=%02h last=%0b", got.rs, got.data, got.last);
            end
          end
        end
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_INIT;
    in_ch.byte_value = '0;
    in_ch.row = 1'b0;
    in_ch.column = '0;
    in_ch.number = '0;
    in_ch.pattern = '0;
    in_ch.pattern_slot = '0;
    out_ch.ready = 1'b0;
    hold_armed = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    mismatch_count = 0;
    cycle_count = 0;
    send_idle_pct = 37;
    recv_idle_pct = 63;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every op, field extremes, zero and ten-digit numbers, unknown ops.
    add_req(OP_INIT, 8'h00, 1'b0, 6'd0, 32'd0, 64'd0, 3'd0);
    add_req(OP_COMMAND, 8'h00, 1'b0, 6'd0, 32'd0, 64'd0, 3'd0);
    add_req(OP_COMMAND, 8'hFF, 1'b1, 6'd63, 32'hFFFF_FFFF, '1, 3'd7);
    add_req(OP_CHAR, 8'h00, 1'b0, 6'd0, 32'd0, 64'd0, 3'd0);
    add_req(OP_CHAR, 8'hFF, 1'b0, 6'd0, 32'd0, 64'd0, 3'd0);
    add_req(OP_CHAR, 8'hA5, 1'b1, 6'd21, 32'd5, 64'd0, 3'd2);
    add_req(OP_GOTO, 8'h00, 1'b0, 6'd0, 32'd0, 64'd0, 3'd0);
    add_req(OP_GOTO, 8'h00, 1'b1, 6'd63, 32'd0, 64'd0, 3'd0);
    add_req(OP_GOTO, 8'hFF, 1'b0, 6'd63, 32'd0, 64'd0, 3'd0);
    add_req(OP_GOTO, 8'h00, 1'b1, 6'd0, 32'd0, 64'd0, 3'd0);
    add_req(OP_NUMBER, 8'h00, 1'b0, 6'd0, 32'd0, 64'd0, 3'd0);
    add_req(OP_NUMBER, 8'h00, 1'b0, 6'd0, 32'd9, 64'd0, 3'd0);
    add_req(OP_NUMBER, 8'h00, 1'b0, 6'd0, 32'd10, 64'd0, 3'd0);
    add_req(OP_NUMBER, 8'h00, 1'b0, 6'd0, 32'hFFFF_FFFF, 64'd0, 3'd0);
    add_req(OP_NUMBER, 8'h00, 1'b0, 6'd0, 32'd1000000000, 64'd0, 3'd0);
    add_req(OP_NUMBER, 8'h00, 1'b0, 6'd0, 32'd4000000000, 64'd0, 3'd0);
    add_req(OP_NUMBER, 8'h00, 1'b0, 6'd0, 32'h8000_0000, 64'd0, 3'd0);
    add_req(OP_GLYPH, 8'h00, 1'b0, 6'd0, 32'd0, 64'd0, 3'd0);
    add_req(OP_GLYPH, 8'hFF, 1'b1, 6'd63, 32'd0, '1, 3'd7);
    add_req(OP_GLYPH, 8'h00, 1'b0, 6'd17, 32'd0, 64'h0123_4567_89AB_CDEF, 3'd5);
    add_req(3'd6, 8'hFF, 1'b1, 6'd63, 32'hFFFF_FFFF, '1, 3'd7);
    add_req(3'd7, 8'h00, 1'b0, 6'd0, 32'd0, 64'd0, 3'd0);
    add_req(OP_COMMAND, 8'h01, 1'b0, 6'd0, 32'd0, 64'd0, 3'd0);
    add_random_reqs(150);
    wait_drained();

    send_idle_pct = 63;
    recv_idle_pct = 37;
    add_random_reqs(75);
    // The sender stops here until the block has delivered everything.
    wait_drained();
    add_random_reqs(75);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // The receiver stalls for a long stretch while requests keep coming.
    hold_armed = ~hold_armed;
    add_random_reqs(150);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    mismatch_count += expected_writes.size();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/clws_pkg.sv
hdl/clws_channels.sv
hdl/clws_digits.sv
hdl/clws_sequencer.sv
hdl/char_lcd_write_sequencer.sv
bench/tb_char_lcd_write_sequencer.sv
